// ===== sv/nlm_pkg.sv =====
package nlm_pkg;

    localparam int BLOCK_PIXELS = 64;
    localparam int IDX_W        = 6;
    localparam int MAX_GROUP    = 32;
    localparam int PIX_W        = 16;
    localparam int WEIGHT_W     = 17;
    localparam int DIV_NUM_W    = 72;
    localparam int DIV_DEN_W    = 64;
    localparam int DIV_CNT_W    = 7;

    typedef enum logic [1:0] {
        REG_SCALE = 2'd0,
        REG_NOISE = 2'd1,
        REG_CORR  = 2'd2,
        REG_LIMIT = 2'd3
    } t_reg;

    typedef struct packed {
        logic [PIX_W-1:0]    pixel;
        logic [PIX_W-1:0]    src;
        logic [IDX_W-1:0]    idx;
        logic [WEIGHT_W-1:0] weight;
        logic                lb;
        logic                lg;
    } t_item;

    typedef enum logic [2:0] {
        F_IDLE,
        F_PROD,
        F_EXP1,
        F_EXP2,
        F_PUSH
    } t_fstate;

    typedef enum logic [4:0] {
        B_IDLE,
        B_ACC1,
        B_ACC2,
        B_ACC3,
        B_EM_RD,
        B_EM_DATA,
        B_DIV_M,
        B_DIV_Q,
        B_MUL_BB,
        B_MUL_AB,
        B_VAR,
        B_CMP,
        B_DIV_R,
        B_MUL_DL,
        B_MUL_DH,
        B_FIN,
        B_OUT
    } t_bstate;

    // exp(-n) for the integer part, Q1.16
    function automatic logic [16:0] exp_int(input logic [3:0] n);
        logic [16:0] v;
        case (n)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd24109;
            4'd2:    v = 17'd8869;
            4'd3:    v = 17'd3263;
            4'd4:    v = 17'd1200;
            4'd5:    v = 17'd442;
            4'd6:    v = 17'd162;
            4'd7:    v = 17'd60;
            4'd8:    v = 17'd22;
            4'd9:    v = 17'd8;
            4'd10:   v = 17'd3;
            4'd11:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic logic [16:0] exp_hi(input logic [3:0] h);
        logic [16:0] v;
        case (h)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd61565;
            4'd2:    v = 17'd57835;
            4'd3:    v = 17'd54331;
            4'd4:    v = 17'd51039;
            4'd5:    v = 17'd47947;
            4'd6:    v = 17'd45042;
            4'd7:    v = 17'd42313;
            4'd8:    v = 17'd39750;
            4'd9:    v = 17'd37341;
            4'd10:   v = 17'd35079;
            4'd11:   v = 17'd32954;
            4'd12:   v = 17'd30957;
            4'd13:   v = 17'd29081;
            4'd14:   v = 17'd27319;
            default: v = 17'd25664;
        endcase
        return v;
    endfunction

    function automatic logic [16:0] exp_lo(input logic [3:0] l);
        logic [16:0] v;
        case (l)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd65280;
            4'd2:    v = 17'd65026;
            4'd3:    v = 17'd64772;
            4'd4:    v = 17'd64520;
            4'd5:    v = 17'd64268;
            4'd6:    v = 17'd64018;
            4'd7:    v = 17'd63768;
            4'd8:    v = 17'd63520;
            4'd9:    v = 17'd63272;
            4'd10:   v = 17'd63025;
            4'd11:   v = 17'd62781;
            4'd12:   v = 17'd62535;
            4'd13:   v = 17'd62291;
            4'd14:   v = 17'd62048;
            default: v = 17'd61806;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/nlmeans_block_weighted_average.sv =====
// Each accepted word holds the front end through its weight lookup (product, two exponent
// steps) and its push to the queue, so no new word is taken until the last one is queued;
// the back end accumulates one word at a time. A group's last word starts emission of 64 words:
// a division per pixel for the mean, with correction a second and the multiplies for variance,
// a third if the variance exceeds the noise; under two blocks or zero weight yield the source.
// Synchronous active-low reset restores the register defaults; results cannot be held off.
module nlmeans_block_weighted_average import nlm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_pixel,
    input  logic [15:0] i_source_pixel,
    input  logic [5:0]  i_pixel_index,
    input  logic [15:0] i_distance,
    input  logic        i_last_in_block,
    input  logic        i_last_in_group,
    output logic        o_valid,
    output logic [15:0] o_filtered_pixel,
    output logic [5:0]  o_out_index,
    output logic        o_last_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [23:0] r_weight_scale;
    logic [31:0] r_noise_variance;
    logic        r_correction_enable;
    logic [5:0]  r_group_limit;
    logic        wr_en;
    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_valid;
    t_item       f_item;
    t_item       q_item;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight_scale      <= 24'd256;
            r_noise_variance    <= 32'd100;
            r_correction_enable <= 1'b0;
            r_group_limit       <= 6'd0;
        end else if (wr_en) begin
            unique case (t_reg'(paddr[3:2]))
                REG_SCALE: r_weight_scale      <= pwdata[23:0];
                REG_NOISE: r_noise_variance    <= pwdata;
                REG_CORR:  r_correction_enable <= pwdata[0];
                REG_LIMIT: r_group_limit       <= pwdata[5:0];
                default:   r_group_limit       <= r_group_limit;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg'(paddr[3:2]))
            REG_SCALE: prdata = {8'd0, r_weight_scale};
            REG_NOISE: prdata = r_noise_variance;
            REG_CORR:  prdata = {31'd0, r_correction_enable};
            REG_LIMIT: prdata = {26'd0, r_group_limit};
            default:   prdata = 32'd0;
        endcase
    end

    nlm_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .o_busy          (busy),
        .i_pixel         (i_pixel),
        .i_source_pixel  (i_source_pixel),
        .i_pixel_index   (i_pixel_index),
        .i_distance      (i_distance),
        .i_last_in_block (i_last_in_block),
        .i_last_in_group (i_last_in_group),
        .i_weight_scale  (r_weight_scale),
        .i_full          (q_full),
        .o_push          (q_push),
        .o_item          (f_item)
    );

    nlm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    nlm_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_q_valid           (q_valid),
        .i_q_item            (q_item),
        .o_q_pop             (q_pop),
        .i_noise_variance    (r_noise_variance),
        .i_correction_enable (r_correction_enable),
        .i_group_limit       (r_group_limit),
        .o_valid             (o_valid),
        .o_filtered_pixel    (o_filtered_pixel),
        .o_out_index         (o_out_index),
        .o_last_result       (o_last_result)
    );

endmodule

// ===== sv/nlm_front.sv =====
module nlm_front import nlm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  logic [15:0]      i_pixel,
    input  logic [15:0]      i_source_pixel,
    input  logic [5:0]       i_pixel_index,
    input  logic [15:0]      i_distance,
    input  logic             i_last_in_block,
    input  logic             i_last_in_group,
    input  logic [23:0]      i_weight_scale,
    input  logic             i_full,
    output logic             o_push,
    output t_item            o_item
);

    t_fstate      r_state, n_state;
    t_item        r_item;
    logic [15:0]  r_dist;
    logic [39:0]  r_prod;
    logic [16:0]  r_t1;
    logic         r_big;
    logic [33:0]  mul1;
    logic [33:0]  mul2;
    logic         accept;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (i_start) n_state = F_PROD;
            F_PROD: n_state = F_EXP1;
            F_EXP1: n_state = F_EXP2;
            F_EXP2: n_state = F_PUSH;
            F_PUSH: if (!i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_busy = (r_state != F_IDLE);
        accept = (r_state == F_IDLE) && i_start;
        o_push = (r_state == F_PUSH) && !i_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Integer part of the exponent is r_prod[39:16]; the weight vanishes from 12 up.
    assign mul1 = exp_int(r_prod[19:16]) * exp_hi(r_prod[15:12]) + 34'd32768;
    assign mul2 = r_t1 * exp_lo(r_prod[11:8]) + 34'd32768;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.pixel  <= i_pixel;
            r_item.src    <= i_source_pixel;
            r_item.idx    <= i_pixel_index;
            r_item.lb     <= i_last_in_block | i_last_in_group;
            r_item.lg     <= i_last_in_group;
            r_item.weight <= '0;
            r_dist        <= i_distance;
        end
        if (r_state == F_PROD) begin
            r_prod <= r_dist * i_weight_scale;
        end
        if (r_state == F_EXP1) begin
            r_big <= (r_prod[39:16] >= 24'd12);
            r_t1  <= mul1[32:16];
        end
        if (r_state == F_EXP2) begin
            r_item.weight <= r_big ? '0 : mul2[32:16];
        end
    end

    assign o_item = r_item;

endmodule

// ===== sv/nlm_queue.sv =====
module nlm_queue import nlm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item       r_mem [2];
    logic        r_wr;
    logic        r_rd;
    logic [1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_item;
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rd];

endmodule

// ===== sv/nlm_div.sv =====
module nlm_div import nlm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic                 o_done,
    output logic [DIV_NUM_W-1:0] o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W:0]   shifted;
    logic [DIV_DEN_W:0]   diff;
    logic                 ge;
    logic [DIV_DEN_W-1:0] n_rem;

    // Restoring division, one quotient bit a cycle; the numerator shifts out
    // of r_quo as the quotient shifts in.
    always_comb begin
        shifted = {r_rem, r_quo[DIV_NUM_W-1]};
        diff    = shifted - {1'b0, r_den};
        ge      = (shifted >= {1'b0, r_den});
        n_rem   = ge ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DIV_NUM_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ===== sv/nlm_back.sv =====
module nlm_back import nlm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_item       i_q_item,
    output logic        o_q_pop,
    input  logic [31:0] i_noise_variance,
    input  logic        i_correction_enable,
    input  logic [5:0]  i_group_limit,
    output logic        o_valid,
    output logic [15:0] o_filtered_pixel,
    output logic [5:0]  o_out_index,
    output logic        o_last_result
);

    t_bstate r_state, n_state;

    logic [47:0] sum_mem [BLOCK_PIXELS];
    logic [63:0] sq_mem  [BLOCK_PIXELS];
    logic [15:0] src_mem [BLOCK_PIXELS];

    t_item       r_it;
    logic        r_use;
    logic [5:0]  r_bc;
    logic [23:0] r_wt;
    logic [BLOCK_PIXELS-1:0] r_vld;
    logic [IDX_W-1:0] r_k;

    logic [47:0] r_sum_rd;
    logic [63:0] r_sq_rd;
    logic [15:0] r_src_rd;
    logic        r_vld_rd;

    logic [32:0] r_wp;
    logic [48:0] r_sqp;
    logic [63:0] r_sq;
    logic [15:0] r_x;
    logic [53:0] r_m;
    logic [63:0] r_q16;
    logic [63:0] r_p1;
    logic [31:0] r_p2;
    logic [63:0] r_v;
    logic [15:0] r_r;
    logic [63:0] r_d;
    logic [47:0] r_pl;
    logic [31:0] r_ph;
    logic [15:0] r_res;

    logic        r_o_valid;
    logic [15:0] r_o_pix;
    logic [5:0]  r_o_idx;
    logic        r_o_last;

    logic [IDX_W-1:0]     rd_addr;
    logic [5:0]           limit;
    logic                 special;
    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quot;
    logic [63:0]          sq_sum;
    logic [63:0]          mm;
    logic [63:0]          var_v;
    logic                 shrink;
    logic [63:0]          dr;
    logic [63:0]          t_val;
    logic [15:0]          fin_pix;
    logic [53:0]          p2_full;
    logic [63:0]          ph_full;

    function automatic logic [15:0] round_mean(input logic [53:0] m);
        logic [54:0] s;
        s = {1'b0, m} + 55'd32768;
        return (|s[54:32]) ? 16'hFFFF : s[31:16];
    endfunction

    nlm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign limit   = (i_group_limit == 6'd0 || i_group_limit > 6'(MAX_GROUP))
                     ? 6'(MAX_GROUP) : i_group_limit;
    assign special = (r_bc < 6'd2) || (r_wt == 24'd0);
    assign shrink  = (r_v > {16'd0, i_noise_variance, 16'd0});

    // Datapath arithmetic of the correction path, all modulo 2^64.
    always_comb begin
        sq_sum  = r_p1 + {r_p2[30:0], 1'b0, 32'd0};
        mm      = {16'd0, sq_sum[63:16]};
        var_v   = (r_q16 > mm) ? (r_q16 - mm) : 64'd0;
        dr      = {16'd0, r_pl} + {r_ph, 32'd0};
        t_val   = {16'd0, r_x, 32'd0} - dr + 64'h0000_0000_8000_0000;
        if (t_val[63]) begin
            fin_pix = 16'd0;
        end else if (|t_val[62:48]) begin
            fin_pix = 16'hFFFF;
        end else begin
            fin_pix = t_val[47:32];
        end
        p2_full = r_m[53:32] * r_m[31:0];
        ph_full = r_d[63:32] * r_r;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE:    if (i_q_valid) n_state = B_ACC1;
            B_ACC1:    n_state = B_ACC2;
            B_ACC2:    n_state = B_ACC3;
            B_ACC3:    n_state = r_it.lg ? B_EM_RD : B_IDLE;
            B_EM_RD:   n_state = B_EM_DATA;
            B_EM_DATA: n_state = special ? B_OUT : B_DIV_M;
            B_DIV_M:   if (div_done) n_state = i_correction_enable ? B_DIV_Q : B_OUT;
            B_DIV_Q:   if (div_done) n_state = B_MUL_BB;
            B_MUL_BB:  n_state = B_MUL_AB;
            B_MUL_AB:  n_state = B_VAR;
            B_VAR:     n_state = B_CMP;
            B_CMP:     n_state = shrink ? B_DIV_R : B_OUT;
            B_DIV_R:   if (div_done) n_state = B_MUL_DL;
            B_MUL_DL:  n_state = B_MUL_DH;
            B_MUL_DH:  n_state = B_FIN;
            B_FIN:     n_state = B_OUT;
            B_OUT:     n_state = (r_k == IDX_W'(BLOCK_PIXELS - 1)) ? B_IDLE : B_EM_RD;
            default:   n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop   = (r_state == B_IDLE) && i_q_valid;
        rd_addr   = (r_state == B_ACC1 || r_state == B_ACC2 || r_state == B_ACC3)
                    ? r_it.idx : r_k;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = {40'd0, r_wt};
        unique case (r_state)
            B_EM_DATA: begin
                div_start = !special;
                div_num   = {8'd0, (r_vld_rd ? r_sum_rd : 48'd0), 16'd0};
            end
            B_DIV_M: begin
                div_start = div_done && i_correction_enable;
                div_num   = {r_sq[55:0], 16'd0};
            end
            B_CMP: begin
                div_start = shrink;
                div_num   = {8'd0, i_noise_variance, 32'd0};
                div_den   = r_v;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_bc      <= '0;
            r_wt      <= '0;
            r_vld     <= '0;
            r_k       <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= (r_state == B_OUT);
            if (r_state == B_ACC3 && r_use) begin
                r_vld[r_it.idx] <= 1'b1;
                if (r_it.lb) begin
                    r_wt <= r_wt + 24'(r_it.weight);
                    r_bc <= r_bc + 6'd1;
                end
            end
            if (r_state == B_OUT) begin
                r_k <= r_k + 1'b1;
                if (r_k == IDX_W'(BLOCK_PIXELS - 1)) begin
                    r_vld <= '0;
                    r_bc  <= '0;
                    r_wt  <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum_rd <= sum_mem[rd_addr];
        r_sq_rd  <= sq_mem[rd_addr];
        r_src_rd <= src_mem[rd_addr];
        r_vld_rd <= r_vld[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_ACC3) begin
            src_mem[r_it.idx] <= r_it.src;
            if (r_use) begin
                sum_mem[r_it.idx] <= (r_vld_rd ? r_sum_rd : 48'd0) + {15'd0, r_wp};
                sq_mem[r_it.idx]  <= (r_vld_rd ? r_sq_rd : 64'd0) + {15'd0, r_sqp};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_it  <= i_q_item;
            r_use <= (r_bc < limit);
        end
        if (r_state == B_ACC1) r_wp  <= r_it.weight * r_it.pixel;
        if (r_state == B_ACC2) r_sqp <= r_wp * r_it.pixel;
        if (r_state == B_EM_DATA) begin
            r_x   <= r_src_rd;
            r_sq  <= r_vld_rd ? r_sq_rd : 64'd0;
            r_res <= r_src_rd;
        end
        if (r_state == B_DIV_M && div_done) begin
            r_m   <= div_quot[53:0];
            r_res <= round_mean(div_quot[53:0]);
        end
        if (r_state == B_DIV_Q && div_done) r_q16 <= div_quot[63:0];
        if (r_state == B_MUL_BB) r_p1 <= r_m[31:0] * r_m[31:0];
        if (r_state == B_MUL_AB) r_p2 <= p2_full[31:0];
        if (r_state == B_VAR)    r_v  <= var_v;
        if (r_state == B_DIV_R && div_done) begin
            r_r <= div_quot[15:0];
            r_d <= {32'd0, r_x, 16'd0} - {10'd0, r_m};
        end
        if (r_state == B_MUL_DL) r_pl <= r_d[31:0] * r_r;
        if (r_state == B_MUL_DH) r_ph <= ph_full[31:0];
        if (r_state == B_FIN)    r_res <= fin_pix;
        if (r_state == B_OUT) begin
            r_o_pix  <= r_res;
            r_o_idx  <= r_k;
            r_o_last <= (r_k == IDX_W'(BLOCK_PIXELS - 1));
        end
    end

    assign o_valid          = r_o_valid;
    assign o_filtered_pixel = r_o_pix;
    assign o_out_index      = r_o_idx;
    assign o_last_result    = r_o_last;

endmodule

// ===== tb/tb.sv =====
module tb;
    import nlm_pkg::*;

    typedef struct packed {
        logic [15:0] pix;
        logic [15:0] src;
        logic [5:0]  idx;
        logic [15:0] distance;
        logic        lb;
        logic        lg;
        logic        has_exp;
        logic [15:0] exp0;
    } pix_word_t;

    typedef struct packed {
        logic [15:0] pix;
        logic [5:0]  idx;
        logic        last;
    } filt_word_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [15:0] i_pixel = '0;
    logic [15:0] i_source_pixel = '0;
    logic [5:0]  i_pixel_index = '0;
    logic [15:0] i_distance = '0;
    logic        i_last_in_block = 1'b0;
    logic        i_last_in_group = 1'b0;
    logic        o_valid;
    logic [15:0] o_filtered_pixel;
    logic [5:0]  o_out_index;
    logic        o_last_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    nlmeans_block_weighted_average u_top (.*);

    always #1 i_clk = ~i_clk;

    // Exponential tables, Q1.16.
    longint unsigned exp_whole[12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8,
                                       3, 1};
    longint unsigned exp_high[16] = '{65536, 61565, 57835, 54331, 51039, 47947, 45042, 42313,
                                      39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664};
    longint unsigned exp_low[16] = '{65536, 65280, 65026, 64772, 64520, 64268, 64018, 63768,
                                     63520, 63272, 63025, 62781, 62535, 62291, 62048, 61806};

    logic [23:0] cfg_scale = 24'd256;
    logic [31:0] cfg_noise = 32'd100;
    logic        cfg_corr = 1'b0;
    logic [5:0]  cfg_limit = 6'd0;

    longint unsigned wsum[64];
    longint unsigned wsq[64];
    logic [15:0]     src_mem[64];
    longint unsigned wtotal = 0;
    int unsigned     nblocks = 0;

    filt_word_t filt_q[$];
    int errors = 0;
    int n_words = 0;
    int n_filtered = 0;
    int n_groups = 0;
    bit idle_en = 1'b1;

    function automatic longint unsigned block_weight(logic [15:0] distance);
        longint unsigned xq, w;
        xq = (longint'(distance) * longint'(cfg_scale)) >> 8;
        if ((xq >> 8) >= 12)
            return 0;
        w = (exp_whole[xq >> 8] * exp_high[(xq >> 4) & 15] + 32768) >> 16;
        return (w * exp_low[xq & 15] + 32768) >> 16;
    endfunction

    function automatic logic [15:0] filtered_value(int k);
        longint unsigned w, x, m, s2, q16, mm, v, r, res;
        longint d, t;
        w = wtotal;
        x = src_mem[k];
        if (nblocks < 2 || w == 0)
            return x[15:0];
        m = (wsum[k] << 16) / w;
        if (cfg_corr) begin
            s2 = wsq[k];
            q16 = ((s2 / w) << 16) + (((s2 % w) << 16) / w);
            mm = (m * m) >> 16;
            v = (q16 > mm) ? q16 - mm : 0;
            if (v > (longint'(cfg_noise) << 16)) begin
                r = (longint'(cfg_noise) << 32) / v;
                d = longint'(x << 16) - longint'(m);
                t = longint'(x << 32) - d * longint'(r) + (longint'(1) << 31);
                if (t < 0)
                    return 16'd0;
                res = longint'(t) >> 32;
                return (res > 65535) ? 16'hFFFF : res[15:0];
            end
        end
        res = (m + 32768) >> 16;
        return (res > 65535) ? 16'hFFFF : res[15:0];
    endfunction

    // Updates the accumulators for one accepted word and queues the block on group end.
    function automatic void accumulate(pix_word_t s);
        int unsigned lim;
        longint unsigned w;
        filt_word_t f;
        lim = (cfg_limit == 0 || cfg_limit > MAX_GROUP) ? MAX_GROUP : cfg_limit;
        src_mem[s.idx] = s.src;
        if (nblocks < lim) begin
            w = block_weight(s.distance);
            wsum[s.idx] += w * s.pix;
            wsq[s.idx] += w * s.pix * s.pix;
            if (s.lb || s.lg) begin
                wtotal += w;
                nblocks++;
            end
        end
        if (s.lg) begin
            for (int k = 0; k < 64; k++) begin
                f.pix = filtered_value(k);
                f.idx = k[5:0];
                f.last = (k == 63);
                if (k == 0 && s.has_exp)
                    f.pix = s.exp0;
                filt_q.push_back(f);
            end
            for (int k = 0; k < 64; k++) begin
                wsum[k] = 0;
                wsq[k] = 0;
            end
            wtotal = 0;
            nblocks = 0;
            n_groups++;
        end
    endfunction

    always @(posedge i_clk) begin
        filt_word_t e;
        if (i_rst_n && o_valid) begin
            n_filtered++;
            if (filt_q.size() == 0) begin
                $error("unexpected filtered word, index %0d", o_out_index);
                errors++;
            end else begin
                e = filt_q.pop_front();
                if (o_filtered_pixel !== e.pix) begin
                    $error("filtered_pixel: expected %0d, got %0d", e.pix, o_filtered_pixel);
                    errors++;
                end
                if (o_out_index !== e.idx) begin
                    $error("out_index: expected %0d, got %0d", e.idx, o_out_index);
                    errors++;
                end
                if (o_last_result !== e.last) begin
                    $error("last_result: expected %0d, got %0d", e.last, o_last_result);
                    errors++;
                end
            end
        end
    end

    // Entered and left at a falling edge.
    task automatic send_word(pix_word_t s);
        while (idle_en && $urandom_range(99) < 37) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start = 1'b1;
        i_pixel = s.pix;
        i_source_pixel = s.src;
        i_pixel_index = s.idx;
        i_distance = s.distance;
        i_last_in_block = s.lb;
        i_last_in_group = s.lg;
        do @(posedge i_clk); while (busy);
        accumulate(s);
        n_words++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        start = 1'b0;
        while (filt_q.size() != 0)
            @(posedge i_clk);
        // Words that raise no result may still be in the pipeline.
        repeat (40) @(negedge i_clk);
    endtask

    task automatic reg_write(t_reg r, logic [31:0] v);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = 4'(4 * int'(r));
        pwdata = v;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (r)
            REG_SCALE: cfg_scale = v[23:0];
            REG_NOISE: cfg_noise = v;
            REG_CORR:  cfg_corr = v[0];
            default:   cfg_limit = v[5:0];
        endcase
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic random_group();
        int nb, sz;
        logic [15:0] bd;
        bit open_end;
        pix_word_t s;
        nb = $urandom_range(1, 5);
        sz = 0;
        if ($urandom_range(7) == 0)
            nb = $urandom_range(30, 36);
        open_end = ($urandom_range(5) == 0);
        for (int b = 0; b < nb; b++) begin
            bd = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000));
            sz = (nb > 10) ? 1 : $urandom_range(1, 4);
            for (int p = 0; p < sz; p++) begin
                s = '0;
                s.pix = 16'($urandom);
                s.src = 16'($urandom);
                s.idx = 6'($urandom);
                s.distance = ($urandom_range(7) == 0) ? 16'($urandom) : bd;
                s.lb = (p == sz - 1) && !(open_end && b == nb - 1);
                s.lg = (p == sz - 1) && (b == nb - 1);
                send_word(s);
            end
        end
    endtask

    // Directed words; a typed value, where given, is the expected pixel at index 0.
    pix_word_t dir_tab[20] = '{
        // two blocks, full weight, black and white pixel
        '{16'd0,     16'd7,     6'd0,  16'd0,     1'b1, 1'b0, 1'b0, 16'd0},
        '{16'hFFFF,  16'd7,     6'd0,  16'd0,     1'b1, 1'b1, 1'b1, 16'd32768},
        // weights underflow to zero, so the source comes back
        '{16'd500,   16'h1234,  6'd0,  16'hFFFF,  1'b1, 1'b0, 1'b0, 16'd0},
        '{16'd900,   16'h1234,  6'd63, 16'hFFFF,  1'b1, 1'b1, 1'b1, 16'h1234},
        // a single block returns the source
        '{16'h00FF,  16'hFFFF,  6'd0,  16'd10,    1'b1, 1'b1, 1'b1, 16'hFFFF},
        // group end closes an open block
        '{16'd100,   16'd3,     6'd1,  16'd5,     1'b0, 1'b0, 1'b0, 16'd0},
        '{16'd200,   16'd4,     6'd2,  16'd5,     1'b1, 1'b0, 1'b0, 16'd0},
        '{16'd300,   16'd5,     6'd1,  16'd40,    1'b0, 1'b1, 1'b0, 16'd0},
        // distance changes within a block
        '{16'hFFFF,  16'hAAAA,  6'd63, 16'd0,     1'b0, 1'b0, 1'b0, 16'd0},
        '{16'h8000,  16'h5555,  6'd63, 16'd255,   1'b0, 1'b0, 1'b0, 16'd0},
        '{16'h0001,  16'hFFFF,  6'd62, 16'd3000,  1'b1, 1'b0, 1'b0, 16'd0},
        '{16'h7FFF,  16'h0000,  6'd63, 16'd1,     1'b1, 1'b0, 1'b0, 16'd0},
        '{16'hFFFE,  16'h8001,  6'd0,  16'd12,    1'b1, 1'b1, 1'b0, 16'd0},
        // four blocks, mixed distances, all pixel bits toggled
        '{16'h5A5A,  16'hA5A5,  6'd21, 16'd700,   1'b1, 1'b0, 1'b0, 16'd0},
        '{16'hA5A5,  16'h5A5A,  6'd42, 16'd2048,  1'b1, 1'b0, 1'b0, 16'd0},
        '{16'h0F0F,  16'hF0F0,  6'd21, 16'hFFFE,  1'b1, 1'b0, 1'b0, 16'd0},
        '{16'hF0F0,  16'h0F0F,  6'd42, 16'd3071,  1'b1, 1'b1, 1'b0, 16'd0},
        // a block closed by a word with both marks, after a closed block; index 0 has no weighted sum
        '{16'd1000,  16'd2000,  6'd5,  16'd0,     1'b1, 1'b0, 1'b0, 16'd0},
        '{16'd3000,  16'd2000,  6'd5,  16'd0,     1'b0, 1'b0, 1'b0, 16'd0},
        '{16'd5000,  16'd2000,  6'd5,  16'd0,     1'b1, 1'b1, 1'b1, 16'd0}
    };

    logic [31:0] phase_set[5][4] = '{
        '{32'd256,       32'd100,        32'd1, 32'd0},
        '{32'hFFFFFF,    32'd0,          32'd1, 32'd1},
        '{32'd0,         32'hFFFFFFFF,   32'd1, 32'd32},
        '{32'd4096,      32'd0,          32'd1, 32'd2},
        '{32'd64,        32'd1000,       32'd0, 32'd63}
    };

    initial begin
        pix_word_t s;
        for (int k = 0; k < 64; k++) begin
            wsum[k] = 0;
            wsq[k] = 0;
            src_mem[k] = '0;
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        // A single full block first, so every source entry is written before any read.
        for (int k = 0; k < 64; k++) begin
            s = '0;
            s.pix = 16'($urandom);
            s.src = 16'(k * 1021);
            s.idx = k[5:0];
            s.lb = (k == 63);
            s.lg = (k == 63);
            send_word(s);
        end
        foreach (dir_tab[i])
            send_word(dir_tab[i]);
        drain();
        for (int ph = 0; ph < 5; ph++) begin
            reg_write(REG_SCALE, phase_set[ph][0]);
            reg_write(REG_NOISE, phase_set[ph][1]);
            reg_write(REG_CORR, phase_set[ph][2]);
            reg_write(REG_LIMIT, phase_set[ph][3]);
            idle_en = (ph != 2);
            for (int n = n_words + 20; n_words < n; )
                random_group();
            drain();
        end
        idle_en = 1'b1;
        reg_write(REG_SCALE, 32'($urandom_range(0, 2048)));
        reg_write(REG_NOISE, 32'($urandom_range(0, 5000)));
        for (int n = n_words + 10; n_words < n; )
            random_group();
        drain();
        $display("Run covered %0d input words in %0d groups and %0d filtered words,",
                 n_words, n_groups, n_filtered);
        $display("over six register settings with correction on and off and limits 1 to 63.");
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #40000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
